### design/bgd_pkg.sv
`default_nettype none
package bgd_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int NUM_COMBOS = 2;
	localparam int DUR_W = 32;
	localparam int CFG_W = 16;
	localparam int MAX_EVENTS = 14;
	localparam int EV_CNT_W = 4;
	localparam int EV_IDX_W = 4;
	localparam logic [CFG_W-1:0] COMBO_WINDOW_MS = 16'd200;

	localparam logic [2:0] EV_CLICK      = 3'd0;
	localparam logic [2:0] EV_HOLD_START = 3'd1;
	localparam logic [2:0] EV_HOLD_RPT   = 3'd2;
	localparam logic [2:0] EV_HOLD_END   = 3'd3;
	localparam logic [2:0] EV_COMBO_A    = 3'd4;
	localparam logic [2:0] EV_COMBO_B    = 3'd5;

	localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [1:0] REG_HOLD_THR   = 2'd1;
	localparam logic [1:0] REG_HOLD_RPT   = 2'd2;
	localparam logic [1:0] REG_COMBO_HOLD = 2'd3;

	typedef struct packed {
		logic [3:0]  raw_levels;
		logic [31:0] now_ms;
	} poll_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [1:0]  button_index;
		logic [31:0] duration_ms;
		logic [3:0]  pressed_mask;
		logic [3:0]  holding_mask;
		logic [1:0]  combo_flags;
		logic        last_event;
	} event_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [1:0]       btn;
		logic [DUR_W-1:0] dur;
	} ev_entry_t;

	typedef struct packed {
		logic gt;
		logic eq;
	} cmp_t;

endpackage
`default_nettype wire

### design/bgd_alu.sv
`default_nettype none
// shared modular subtract and threshold compare
module bgd_alu #(
	parameter int TIME_BITS = 32
) (
	input  wire logic [TIME_BITS-1:0] a,
	input  wire logic [TIME_BITS-1:0] b,
	input  wire logic [TIME_BITS-1:0] thr,
	output logic [TIME_BITS-1:0]      diff,
	output bgd_pkg::cmp_t             cmp
);
	always_comb begin
		diff = a - b;
		cmp.gt = diff > thr;
		cmp.eq = diff == thr;
	end
endmodule
`default_nettype wire

### design/bgd_evbuf.sv
`default_nettype none
module bgd_evbuf (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              clear,
	input  wire logic                              push,
	input  wire bgd_pkg::ev_entry_t                wr_ev,
	input  wire logic [bgd_pkg::EV_IDX_W-1:0]      rd_idx,
	output bgd_pkg::ev_entry_t                     rd_ev,
	output logic [bgd_pkg::EV_CNT_W-1:0]           count
);
	bgd_pkg::ev_entry_t buf_q [bgd_pkg::MAX_EVENTS];
	logic [bgd_pkg::EV_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clear) begin
			cnt_q <= '0;
		end else if (push && cnt_q < bgd_pkg::EV_CNT_W'(bgd_pkg::MAX_EVENTS)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clear && push && cnt_q < bgd_pkg::EV_CNT_W'(bgd_pkg::MAX_EVENTS)) begin
			buf_q[cnt_q[bgd_pkg::EV_IDX_W-1:0]] <= wr_ev;
		end
	end

	assign rd_ev = buf_q[rd_idx];
	assign count = cnt_q;
endmodule
`default_nettype wire

### design/button_gesture_detector.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  poll_t (raw_levels, now_ms)
// out      output     out_valid / out_stall event_t, one per event
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
// After acceptance a poll steps through debounce of each button (with a release step per
// release), the combo checks, hold start and hold repeat of each button (with a step per
// repeat) and the combo-duration checks, then hands out its buffered events in order.
// in_stall is high from acceptance until the last event of that poll is taken, if it has any.
// Events are buffered, then presented in order; out_stall simply holds the current one.
// arst_n clears all button, combo and sequencer state; registers return to defaults.
`default_nettype none
module button_gesture_detector #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire bgd_pkg::poll_t              in_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output bgd_pkg::event_t                  out_data,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [bgd_pkg::CFG_W-1:0]   cfg_data
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DEB  = 4'd1;
	localparam logic [3:0] ST_REL  = 4'd2;
	localparam logic [3:0] ST_CA1  = 4'd3;
	localparam logic [3:0] ST_CA2  = 4'd4;
	localparam logic [3:0] ST_HS   = 4'd5;
	localparam logic [3:0] ST_HR1  = 4'd6;
	localparam logic [3:0] ST_HR2  = 4'd7;
	localparam logic [3:0] ST_CD   = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0] st_q;
	logic [1:0] idx_q;
	logic [bgd_pkg::EV_IDX_W-1:0] rd_q;

	logic [bgd_pkg::CFG_W-1:0] deb_q, hthr_q, hrpt_q, chold_q;

	logic [3:0]           raw_q;
	logic [TIME_BITS-1:0] now_q;

	logic [3:0] prev_q, filt_q, pressed_q, hold_q, click_q, claim_q;
	logic [TIME_BITS-1:0] ct_q  [bgd_pkg::NUM_BUTTONS];
	logic [TIME_BITS-1:0] ps_q  [bgd_pkg::NUM_BUTTONS];
	logic [TIME_BITS-1:0] lrt_q [bgd_pkg::NUM_BUTTONS];
	logic [1:0] cact_q, crep_q;
	logic [TIME_BITS-1:0] cst_q [bgd_pkg::NUM_COMBOS];
	logic ab_ok_q;

	logic [TIME_BITS-1:0] alu_a, alu_b, alu_thr, diff;
	bgd_pkg::cmp_t cmp;
	logic [TIME_BITS-1:0] ct_eff;
	logic r_bit, any_combo, combo_sel;
	logic [1:0] pa, pb;
	logic ge, lt;

	logic push, buf_clear;
	bgd_pkg::ev_entry_t wr_ev, rd_ev;
	logic [bgd_pkg::EV_CNT_W-1:0] ev_cnt;

	assign r_bit = raw_q[idx_q];
	assign ct_eff = (r_bit != prev_q[idx_q]) ? now_q : ct_q[idx_q];
	assign any_combo = |cact_q;
	assign combo_sel = idx_q[0];
	assign pa = combo_sel ? 2'd1 : 2'd0;
	assign pb = combo_sel ? 2'd2 : 2'd3;
	assign ge = cmp.gt | cmp.eq;
	assign lt = ~ge;

	always_comb begin
		alu_a = now_q;
		alu_b = ps_q[idx_q];
		alu_thr = TIME_BITS'(hthr_q);
		unique case (st_q)
			ST_DEB: begin
				alu_b = ct_eff;
				alu_thr = TIME_BITS'(deb_q);
			end
			ST_CA1: begin
				alu_a = ps_q[pa];
				alu_b = ps_q[pb];
				alu_thr = TIME_BITS'(bgd_pkg::COMBO_WINDOW_MS);
			end
			ST_CA2: begin
				alu_a = ps_q[pb];
				alu_b = ps_q[pa];
				alu_thr = TIME_BITS'(bgd_pkg::COMBO_WINDOW_MS);
			end
			ST_HR1: begin
				alu_b = lrt_q[idx_q];
				alu_thr = TIME_BITS'(hrpt_q);
			end
			ST_CD: begin
				alu_b = cst_q[combo_sel];
				alu_thr = TIME_BITS'(chold_q);
			end
			default: begin
			end
		endcase
	end

	bgd_alu #(.TIME_BITS(TIME_BITS)) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.thr  (alu_thr),
		.diff (diff),
		.cmp  (cmp)
	);

	// event generation for the current step
	always_comb begin
		push = 1'b0;
		wr_ev.kind = bgd_pkg::EV_CLICK;
		wr_ev.btn = idx_q;
		wr_ev.dur = bgd_pkg::DUR_W'(diff);
		unique case (st_q)
			ST_REL: begin
				if (hold_q[idx_q] && !any_combo) begin
					push = 1'b1;
					wr_ev.kind = bgd_pkg::EV_HOLD_END;
				end else if (click_q[idx_q] && !any_combo && lt) begin
					push = 1'b1;
					wr_ev.kind = bgd_pkg::EV_CLICK;
					wr_ev.dur = '0;
				end
			end
			ST_HS: begin
				if (!any_combo && pressed_q[idx_q] && !hold_q[idx_q] &&
				    !claim_q[idx_q] && ge) begin
					push = 1'b1;
					wr_ev.kind = bgd_pkg::EV_HOLD_START;
				end
			end
			ST_HR2: begin
				push = 1'b1;
				wr_ev.kind = bgd_pkg::EV_HOLD_RPT;
			end
			ST_CD: begin
				if (cact_q[combo_sel] && !crep_q[combo_sel] && ge) begin
					push = 1'b1;
					wr_ev.kind = combo_sel ? bgd_pkg::EV_COMBO_B : bgd_pkg::EV_COMBO_A;
					wr_ev.btn = '0;
					wr_ev.dur = '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign buf_clear = (st_q == ST_IDLE);

	bgd_evbuf u_evbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (buf_clear),
		.push   (push),
		.wr_ev  (wr_ev),
		.rd_idx (rd_q),
		.rd_ev  (rd_ev),
		.count  (ev_cnt)
	);

	assign in_stall = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = (st_q == ST_OUT) && (ev_cnt != '0);

	always_comb begin
		out_data.event_kind = rd_ev.kind;
		out_data.button_index = rd_ev.btn;
		out_data.duration_ms = rd_ev.dur;
		out_data.pressed_mask = pressed_q;
		out_data.holding_mask = hold_q;
		out_data.combo_flags = cact_q;
		out_data.last_event = (bgd_pkg::EV_CNT_W'(rd_q) + 1'b1) == ev_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q <= 16'd50;
			hthr_q <= 16'd1000;
			hrpt_q <= 16'd100;
			chold_q <= 16'd2000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bgd_pkg::REG_DEBOUNCE:   deb_q <= cfg_data;
				bgd_pkg::REG_HOLD_THR:   hthr_q <= cfg_data;
				bgd_pkg::REG_HOLD_RPT:   hrpt_q <= cfg_data;
				bgd_pkg::REG_COMBO_HOLD: chold_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			raw_q <= in_data.raw_levels;
			now_q <= TIME_BITS'(in_data.now_ms);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			idx_q <= '0;
			rd_q <= '0;
			ab_ok_q <= 1'b0;
			prev_q <= '0;
			filt_q <= '0;
			pressed_q <= '0;
			hold_q <= '0;
			click_q <= '0;
			claim_q <= '0;
			cact_q <= '0;
			crep_q <= '0;
			for (int i = 0; i < bgd_pkg::NUM_BUTTONS; i++) begin
				ct_q[i] <= '0;
				ps_q[i] <= '0;
				lrt_q[i] <= '0;
			end
			for (int c = 0; c < bgd_pkg::NUM_COMBOS; c++) begin
				cst_q[c] <= '0;
			end
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_DEB;
						idx_q <= '0;
						rd_q <= '0;
					end
				end
				ST_DEB: begin
					prev_q[idx_q] <= r_bit;
					ct_q[idx_q] <= ct_eff;
					if (cmp.gt && r_bit != filt_q[idx_q] && r_bit != pressed_q[idx_q]) begin
						filt_q[idx_q] <= r_bit;
						pressed_q[idx_q] <= r_bit;
						if (r_bit) begin
							ps_q[idx_q] <= now_q;
							click_q[idx_q] <= 1'b1;
							claim_q[idx_q] <= 1'b0;
						end
					end else if (cmp.gt && r_bit != filt_q[idx_q]) begin
						filt_q[idx_q] <= r_bit;
					end
					if (cmp.gt && r_bit != filt_q[idx_q] && r_bit != pressed_q[idx_q] &&
					    !r_bit) begin
						st_q <= ST_REL;
					end else if (idx_q == 2'd3) begin
						st_q <= ST_CA1;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_REL: begin
					hold_q[idx_q] <= 1'b0;
					click_q[idx_q] <= 1'b0;
					// combo ends once both of its buttons are up
					if (cact_q[0] && (idx_q == 2'd0 || idx_q == 2'd3) &&
					    !pressed_q[0] && !pressed_q[3]) begin
						cact_q[0] <= 1'b0;
						crep_q[0] <= 1'b0;
						hold_q[0] <= 1'b0; click_q[0] <= 1'b0; claim_q[0] <= 1'b0;
						hold_q[3] <= 1'b0; click_q[3] <= 1'b0; claim_q[3] <= 1'b0;
					end
					if (cact_q[1] && (idx_q == 2'd1 || idx_q == 2'd2) &&
					    !pressed_q[1] && !pressed_q[2]) begin
						cact_q[1] <= 1'b0;
						crep_q[1] <= 1'b0;
						hold_q[1] <= 1'b0; click_q[1] <= 1'b0; claim_q[1] <= 1'b0;
						hold_q[2] <= 1'b0; click_q[2] <= 1'b0; claim_q[2] <= 1'b0;
					end
					if (idx_q == 2'd3) begin
						st_q <= ST_CA1;
						idx_q <= '0;
					end else begin
						st_q <= ST_DEB;
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CA1: begin
					ab_ok_q <= ~cmp.gt;
					st_q <= ST_CA2;
				end
				ST_CA2: begin
					if (!cact_q[combo_sel] && pressed_q[pa] && pressed_q[pb] &&
					    (ab_ok_q || !cmp.gt)) begin
						cact_q[combo_sel] <= 1'b1;
						crep_q[combo_sel] <= 1'b0;
						cst_q[combo_sel] <= ab_ok_q ? ps_q[pa] : ps_q[pb];
						click_q[pa] <= 1'b0;
						click_q[pb] <= 1'b0;
						claim_q[pa] <= 1'b1;
						claim_q[pb] <= 1'b1;
					end
					if (combo_sel) begin
						st_q <= ST_HS;
						idx_q <= '0;
					end else begin
						st_q <= ST_CA1;
						idx_q <= 2'd1;
					end
				end
				ST_HS: begin
					if (push) begin
						hold_q[idx_q] <= 1'b1;
						lrt_q[idx_q] <= now_q;
						click_q[idx_q] <= 1'b0;
					end
					if (idx_q == 2'd3) begin
						st_q <= ST_HR1;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_HR1: begin
					if (hold_q[idx_q] && !any_combo && ge) begin
						lrt_q[idx_q] <= now_q;
						st_q <= ST_HR2;
					end else if (idx_q == 2'd3) begin
						st_q <= ST_CD;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_HR2: begin
					if (idx_q == 2'd3) begin
						st_q <= ST_CD;
						idx_q <= '0;
					end else begin
						st_q <= ST_HR1;
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CD: begin
					if (push) begin
						crep_q[combo_sel] <= 1'b1;
					end
					if (combo_sel) begin
						st_q <= ST_OUT;
						idx_q <= '0;
					end else begin
						idx_q <= 2'd1;
					end
				end
				ST_OUT: begin
					if (ev_cnt == '0) begin
						st_q <= ST_IDLE;
					end else if (!out_stall) begin
						if (out_data.last_event) begin
							st_q <= ST_IDLE;
							rd_q <= '0;
						end else begin
							rd_q <= rd_q + 1'b1;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire
